FILE: hdl/shdt_pkg.sv
// Package: shared types, constants and scan tables for the delimiter tokenizer.
`default_nettype none
package shdt_pkg;

  localparam int CHAR_CLASSES = 256;
  localparam int CHAR_W       = 8;
  localparam int MASK_W       = 64;
  localparam int MASK_WORDS   = CHAR_CLASSES / MASK_W;
  localparam int WORD_AW      = $clog2(MASK_WORDS);
  localparam int BIT_AW       = $clog2(MASK_W);
  localparam int CFG_IDX_W    = WORD_AW + 1;
  localparam int CFG_BANK_BIT = WORD_AW;
  localparam int OUT_DATA_W   = 16;
  localparam int OUT_PAD_W    = OUT_DATA_W - CHAR_W - 2;

  typedef enum logic [1:0] {
    ST_START = 2'd0,
    ST_SOFTD = 2'd1,
    ST_HARDD = 2'd2,
    ST_TOKEN = 2'd3
  } scan_state_t;

  typedef enum logic [1:0] {
    CL_TOK = 2'd0,
    CL_SFT = 2'd1,
    CL_HRD = 2'd2,
    CL_END = 2'd3
  } char_class_t;

  typedef enum logic [1:0] {
    ACT_TOKEN = 2'd0,
    ACT_DELIM = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_LEAD  = 2'd3
  } scan_act_t;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_DELIM = 2'd1,
    KIND_GROUP = 2'd2,
    KIND_END   = 2'd3
  } out_kind_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] chr;
    char_class_t       cls;
  } class_item_t;

  function automatic scan_state_t next_state(scan_state_t s, char_class_t c);
    scan_state_t n;
    n = ST_START;
    case (s)
      ST_START: begin
        case (c)
          CL_TOK:  n = ST_TOKEN;
          CL_HRD:  n = ST_HARDD;
          default: n = ST_START;
        endcase
      end
      ST_SOFTD: begin
        case (c)
          CL_SFT:  n = ST_SOFTD;
          CL_HRD:  n = ST_HARDD;
          default: n = ST_START;
        endcase
      end
      ST_HARDD: begin
        case (c)
          CL_SFT:  n = ST_HARDD;
          default: n = ST_START;
        endcase
      end
      ST_TOKEN: begin
        case (c)
          CL_TOK:  n = ST_TOKEN;
          CL_SFT:  n = ST_SOFTD;
          CL_HRD:  n = ST_HARDD;
          default: n = ST_START;
        endcase
      end
      default: n = ST_START;
    endcase
    return n;
  endfunction

  function automatic scan_act_t scan_action(scan_state_t s, char_class_t c);
    scan_act_t a;
    a = ACT_CLOSE;
    case (s)
      ST_START: begin
        case (c)
          CL_TOK:  a = ACT_TOKEN;
          CL_SFT:  a = ACT_LEAD;
          CL_HRD:  a = ACT_DELIM;
          default: a = ACT_CLOSE;
        endcase
      end
      ST_SOFTD: begin
        case (c)
          CL_SFT:  a = ACT_DELIM;
          CL_HRD:  a = ACT_DELIM;
          default: a = ACT_CLOSE;
        endcase
      end
      ST_HARDD: begin
        case (c)
          CL_SFT:  a = ACT_DELIM;
          default: a = ACT_CLOSE;
        endcase
      end
      ST_TOKEN: begin
        case (c)
          CL_TOK:  a = ACT_TOKEN;
          CL_SFT:  a = ACT_DELIM;
          CL_HRD:  a = ACT_DELIM;
          default: a = ACT_CLOSE;
        endcase
      end
      default: a = ACT_CLOSE;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/shdt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module shdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hdl/shdt_class.sv
// Classifier stage: mask memories, request hold register and character class lookup.
`default_nettype none
module shdt_class (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [shdt_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [shdt_pkg::MASK_W-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [shdt_pkg::CHAR_W-1:0]    in_chr,
  input  wire logic                           consume,
  output      shdt_pkg::class_item_t          item
);

  logic                              v1_r;
  logic [shdt_pkg::CHAR_W-1:0]       chr_r;
  logic [shdt_pkg::MASK_WORDS-1:0]   soft_vld_r;
  logic [shdt_pkg::MASK_WORDS-1:0]   hard_vld_r;
  logic                              soft_we;
  logic                              hard_we;
  logic                              in_fire;
  logic [shdt_pkg::WORD_AW-1:0]      cfg_word;
  logic [shdt_pkg::WORD_AW-1:0]      rd_word;
  logic [shdt_pkg::WORD_AW-1:0]      held_word;
  logic [shdt_pkg::BIT_AW-1:0]       held_bit;
  logic [shdt_pkg::MASK_W-1:0]       soft_rd;
  logic [shdt_pkg::MASK_W-1:0]       hard_rd;
  logic                              soft_hit;
  logic                              hard_hit;

  assign cfg_word  = cfg_addr[shdt_pkg::WORD_AW-1:0];
  assign soft_we   = cfg_wr_en && !cfg_addr[shdt_pkg::CFG_BANK_BIT];
  assign hard_we   = cfg_wr_en && cfg_addr[shdt_pkg::CFG_BANK_BIT];
  assign in_ready  = !v1_r || consume;
  assign in_fire   = in_valid && in_ready;
  assign rd_word   = in_chr[shdt_pkg::CHAR_W-1 -: shdt_pkg::WORD_AW];
  assign held_word = chr_r[shdt_pkg::CHAR_W-1 -: shdt_pkg::WORD_AW];
  assign held_bit  = chr_r[shdt_pkg::BIT_AW-1:0];

  shdt_ram #(
    .WIDTH (shdt_pkg::MASK_W),
    .DEPTH (shdt_pkg::MASK_WORDS)
  ) u_soft_ram (
    .clk   (clk),
    .we    (soft_we),
    .waddr (cfg_word),
    .wdata (cfg_wdata),
    .re    (in_fire),
    .raddr (rd_word),
    .rdata (soft_rd)
  );

  shdt_ram #(
    .WIDTH (shdt_pkg::MASK_W),
    .DEPTH (shdt_pkg::MASK_WORDS)
  ) u_hard_ram (
    .clk   (clk),
    .we    (hard_we),
    .waddr (cfg_word),
    .wdata (cfg_wdata),
    .re    (in_fire),
    .raddr (rd_word),
    .rdata (hard_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      soft_vld_r <= '0;
      hard_vld_r <= '0;
    end else begin
      if (in_fire) begin
        v1_r <= 1'b1;
      end else if (consume) begin
        v1_r <= 1'b0;
      end
      if (soft_we) begin
        soft_vld_r[cfg_word] <= 1'b1;
      end
      if (hard_we) begin
        hard_vld_r[cfg_word] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      chr_r <= in_chr;
    end
  end

  assign soft_hit = soft_vld_r[held_word] && soft_rd[held_bit];
  assign hard_hit = hard_vld_r[held_word] && hard_rd[held_bit];

  always_comb begin
    item.valid = v1_r;
    item.chr   = chr_r;
    if (chr_r == '0) begin
      item.cls = shdt_pkg::CL_END;
    end else if (hard_hit) begin
      item.cls = shdt_pkg::CL_HRD;
    end else if (soft_hit) begin
      item.cls = shdt_pkg::CL_SFT;
    end else begin
      item.cls = shdt_pkg::CL_TOK;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/shdt_scan.sv
// Scanner: state machine, group flags and output register.
`default_nettype none
module shdt_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire shdt_pkg::class_item_t         item,
  output      logic                          consume,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      shdt_pkg::out_kind_t           out_kind,
  output      logic [shdt_pkg::CHAR_W-1:0]   out_chr,
  output      logic                          out_hard,
  output      logic                          out_soft,
  output      logic                          out_last
);

  shdt_pkg::scan_state_t       state_r, state_nxt;
  logic                        seen_hard_r, seen_hard_nxt;
  logic                        seen_soft_r, seen_soft_nxt;
  logic                        out_valid_r;
  shdt_pkg::out_kind_t         kind_r, kind_nxt;
  logic [shdt_pkg::CHAR_W-1:0] chr_r, chr_nxt;
  logic                        hard_r, hard_nxt;
  logic                        soft_r, soft_nxt;
  logic                        last_r, last_nxt;
  logic                        out_free;
  logic                        fire;
  shdt_pkg::scan_act_t         act;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = item.valid && out_free;
  assign act      = shdt_pkg::scan_action(state_r, item.cls);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shdt_pkg::ST_START;
      seen_hard_r <= 1'b0;
      seen_soft_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_hard_r <= seen_hard_nxt;
      seen_soft_r <= seen_soft_nxt;
      if (out_free) begin
        out_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r <= kind_nxt;
      chr_r  <= chr_nxt;
      hard_r <= hard_nxt;
      soft_r <= soft_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    seen_hard_nxt = seen_hard_r;
    seen_soft_nxt = seen_soft_r;
    consume       = 1'b0;
    kind_nxt      = shdt_pkg::KIND_DELIM;
    chr_nxt       = item.chr;
    hard_nxt      = 1'b0;
    soft_nxt      = 1'b0;
    last_nxt      = 1'b1;
    if (fire) begin
      if (act == shdt_pkg::ACT_CLOSE && state_r != shdt_pkg::ST_START) begin
        // emit boundary, hold the byte for a rescan from start
        kind_nxt      = shdt_pkg::KIND_GROUP;
        chr_nxt       = '0;
        hard_nxt      = seen_hard_r;
        soft_nxt      = seen_soft_r;
        last_nxt      = 1'b0;
        state_nxt     = shdt_pkg::ST_START;
        seen_hard_nxt = 1'b0;
        seen_soft_nxt = 1'b0;
      end else if (item.cls == shdt_pkg::CL_END) begin
        kind_nxt      = shdt_pkg::KIND_END;
        chr_nxt       = '0;
        consume       = 1'b1;
        state_nxt     = shdt_pkg::ST_START;
        seen_hard_nxt = 1'b0;
        seen_soft_nxt = 1'b0;
      end else if (act == shdt_pkg::ACT_TOKEN) begin
        kind_nxt  = shdt_pkg::KIND_TOKEN;
        consume   = 1'b1;
        state_nxt = shdt_pkg::next_state(state_r, item.cls);
      end else begin
        kind_nxt  = shdt_pkg::KIND_DELIM;
        consume   = 1'b1;
        state_nxt = shdt_pkg::next_state(state_r, item.cls);
        if (act == shdt_pkg::ACT_DELIM) begin
          if (item.cls == shdt_pkg::CL_HRD) begin
            seen_hard_nxt = 1'b1;
          end else begin
            seen_soft_nxt = 1'b1;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_chr   = chr_r;
  assign out_hard  = hard_r;
  assign out_soft  = soft_r;
  assign out_last  = last_r;

  a_group_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == shdt_pkg::KIND_GROUP |-> !last_r)
    else $error("boundary result marked last");

  a_group_then_rescan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && kind_r == shdt_pkg::KIND_GROUP |=> out_valid_r && last_r)
    else $error("boundary not followed by rescan result");

  a_flags_only_on_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != shdt_pkg::KIND_GROUP |-> !hard_r && !soft_r)
    else $error("group flags set on non-boundary result");

  a_end_resets_scan: assert property (@(posedge clk) disable iff (!rst_n)
    fire && consume && item.cls == shdt_pkg::CL_END |=>
      state_r == shdt_pkg::ST_START && !seen_hard_r && !seen_soft_r)
    else $error("scanner not back at start after end of string");

endmodule
`default_nettype wire

FILE: hdl/soft_hard_delimiter_tokenizer.sv
// Top level: soft/hard delimiter string tokenizer.
//
//   channel  ports                      contents (low bit up)
//   in       in_tvalid/tready/tdata     tdata: char_byte[7:0]
//   out      out_tvalid/tready/tdata    tdata: out_byte[7:0], group_has_hard, group_has_soft,
//            out_tuser/out_tlast        zero pad; tuser: kind; tlast: last_result
//   cfg      cfg_wr_en/addr/wdata       addr 0-3 soft masks, 4-7 hard masks
//
// One byte per cycle while the output is not stalled and no group closes; a byte that closes
// a delimiter group gives two results (boundary result, then the rescan from start).
// Each byte passes the mask memory read register, then the scan into the output register.
// Synchronous active-low reset clears the scan state, group flags and mask valid bits.
// A stalled output holds the result register and backs up the input through one byte.
`default_nettype none
module soft_hard_delimiter_tokenizer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [shdt_pkg::CHAR_W-1:0]    in_tdata,   // char_byte
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [shdt_pkg::OUT_DATA_W-1:0] out_tdata, // out_byte, group_has_hard, group_has_soft
  output      logic [1:0]                     out_tuser,  // kind
  output      logic                           out_tlast,
  input  wire logic                           cfg_wr_en,
  input  wire logic [shdt_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [shdt_pkg::MASK_W-1:0]    cfg_wdata
);

  shdt_pkg::class_item_t       item;
  logic                        consume;
  shdt_pkg::out_kind_t         kind;
  logic [shdt_pkg::CHAR_W-1:0] chr;
  logic                        hard_flag;
  logic                        soft_flag;

  shdt_class u_class (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_chr    (in_tdata),
    .consume   (consume),
    .item      (item)
  );

  shdt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .consume   (consume),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind),
    .out_chr   (chr),
    .out_hard  (hard_flag),
    .out_soft  (soft_flag),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{shdt_pkg::OUT_PAD_W{1'b0}}, soft_flag, hard_flag, chr};
  assign out_tuser = kind;

endmodule
`default_nettype wire
